// ----- rtl/oust_pkg.sv -----
package oust_pkg;

    localparam int CNT_W = 7;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD    = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_CHECK  = 2'd2;
    localparam t_op OP_LIST   = 2'd3;

    typedef logic [1:0] t_cell_cmd;
    localparam t_cell_cmd CMD_HOLD   = 2'd0;
    localparam t_cell_cmd CMD_APPEND = 2'd1;
    localparam t_cell_cmd CMD_REMOVE = 2'd2;
    localparam t_cell_cmd CMD_ROTATE = 2'd3;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  slot;
    } t_cell_ctrl;

endpackage

// ----- rtl/oust_if.sv -----
interface oust_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] element;

    modport source (output valid, output op, output element, input ready);
    modport sink   (input valid, input op, input element, output ready);
endinterface

interface oust_out_if;
    logic       valid;
    logic       ready;
    logic       was_member;
    logic       add_refused;
    logic [6:0] member_count;
    logic [7:0] listed_element;
    logic       listed_valid;
    logic       last;

    modport source (output valid, output was_member, output add_refused,
                    output member_count, output listed_element,
                    output listed_valid, output last, input ready);
    modport sink   (input valid, input was_member, input add_refused,
                    input member_count, input listed_element,
                    input listed_valid, input last, output ready);
endinterface

// ----- rtl/oust_cell.sv -----
module oust_cell #(
    parameter int INDEX        = 0,
    parameter int ELEMENT_BITS = 8
) (
    input  logic                          i_clk,
    input  oust_pkg::t_cell_ctrl          i_ctrl,
    input  logic [ELEMENT_BITS-1:0]       i_elem,
    input  logic [ELEMENT_BITS-1:0]       i_next,
    input  logic [ELEMENT_BITS-1:0]       i_head,
    output logic [ELEMENT_BITS-1:0]       o_value,
    output logic                          o_hit
);

    localparam logic [oust_pkg::CNT_W-1:0] IDX = oust_pkg::CNT_W'(INDEX);

    logic [ELEMENT_BITS-1:0]    r_val;
    logic [ELEMENT_BITS-1:0]    n_val;
    logic [oust_pkg::CNT_W-1:0] w_tail;

    assign w_tail  = i_ctrl.count - oust_pkg::CNT_W'(1);
    assign o_value = r_val;
    assign o_hit   = (IDX < i_ctrl.count) && (r_val == i_elem);

    always_comb begin
        n_val = r_val;
        case (i_ctrl.cmd)
            oust_pkg::CMD_APPEND: begin
                if (IDX == i_ctrl.count) n_val = i_elem;
            end
            oust_pkg::CMD_REMOVE: begin
                if (IDX >= i_ctrl.slot) n_val = i_next;
            end
            oust_pkg::CMD_ROTATE: begin
                n_val = (IDX == w_tail) ? i_head : i_next;
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- rtl/ordered_unique_set_table.sv -----
// Add, remove and check: the item goes to the execute state, which registers the result;
// no new item is taken until the last result is registered. List: elements come from the
// head cell, one element per cycle while the sink does not stall, as the chain rotates one place.
// Output register holds a result while the sink stalls; the chain stalls with it.
// Reset (synchronous, active low) clears the count, the state and the output valid.
module ordered_unique_set_table #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    oust_in_if.sink           i_in,
    oust_out_if.source        o_out
);

    localparam int CW = oust_pkg::CNT_W;
    localparam int EW = ELEMENT_BITS;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]          r_state, n_state;
    oust_pkg::t_op       r_op;
    logic [EW-1:0]       r_elem;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_left, n_left;

    logic                r_out_valid, n_out_valid;
    logic                r_was, n_was;
    logic                r_refused, n_refused;
    logic [7:0]          r_listed, n_listed;
    logic                r_lvalid, n_lvalid;
    logic                r_last, n_last;

    oust_pkg::t_cell_ctrl w_ctrl;
    logic [EW-1:0]       w_val [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    logic                w_any;
    logic [CW-1:0]       w_slot;
    logic                w_free;
    logic [31:0]         w_in_ext;
    logic [31:0]         w_head_ext;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_free     = !r_out_valid || o_out.ready;
    assign w_in_ext   = 32'(i_in.element);
    assign w_head_ext = 32'(w_val[0]);
    assign w_any      = |w_hit;

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_hit[i]) w_slot = w_slot | CW'(i);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [EW-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_end
            assign w_next = w_val[0];
        end else begin : g_mid
            assign w_next = w_val[g+1];
        end
        oust_cell #(.INDEX(g), .ELEMENT_BITS(EW)) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_elem  (r_elem),
            .i_next  (w_next),
            .i_head  (w_val[0]),
            .o_value (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_was       = r_was;
        n_refused   = r_refused;
        n_listed    = r_listed;
        n_lvalid    = r_lvalid;
        n_last      = r_last;
        w_ctrl.cmd  = oust_pkg::CMD_HOLD;
        w_ctrl.count = r_count;
        w_ctrl.slot  = w_slot;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == oust_pkg::OP_LIST && r_count != '0) begin
                    n_left  = r_count;
                    n_state = ST_LIST;
                end else if (w_free) begin
                    n_out_valid = 1'b1;
                    n_was       = w_any && (r_op != oust_pkg::OP_LIST);
                    n_refused   = 1'b0;
                    n_listed    = '0;
                    n_lvalid    = 1'b0;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_op == oust_pkg::OP_ADD && !w_any) begin
                        if (r_count < CAP) begin
                            w_ctrl.cmd = oust_pkg::CMD_APPEND;
                            n_count    = r_count + CW'(1);
                        end else begin
                            n_refused = 1'b1;
                        end
                    end else if (r_op == oust_pkg::OP_REMOVE && w_any) begin
                        w_ctrl.cmd = oust_pkg::CMD_REMOVE;
                        n_count    = r_count - CW'(1);
                    end
                end
            end
            ST_LIST: begin
                if (w_free) begin
                    w_ctrl.cmd  = oust_pkg::CMD_ROTATE;
                    n_out_valid = 1'b1;
                    n_was       = 1'b0;
                    n_refused   = 1'b0;
                    n_listed    = w_head_ext[7:0];
                    n_lvalid    = 1'b1;
                    n_last      = (r_left == CW'(1));
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.op;
            r_elem <= w_in_ext[EW-1:0];
        end
        r_was     <= n_was;
        r_refused <= n_refused;
        r_listed  <= n_listed;
        r_lvalid  <= n_lvalid;
        r_last    <= n_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.was_member     = r_was;
    assign o_out.add_refused    = r_refused;
    assign o_out.member_count   = 7'(r_count);
    assign o_out.listed_element = r_listed;
    assign o_out.listed_valid   = r_lvalid;
    assign o_out.last           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP) else $error("count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_EXEC))
        else $error("accepted item not executed");

    a_list_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> (r_left != '0 && r_left <= r_count))
        else $error("list run out of range");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_refused) |-> (r_count == CAP))
        else $error("add refused while not full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC) |=> (r_count == $past(r_count)))
        else $error("count changed outside execute");

endmodule
